// ===== design/tpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tpm_pkg;

	localparam int MaxPlanePixels = 4194304;
	localparam int PlaneCount = 3;
	localparam int CountW = 23;
	localparam int SqSumW = 38;
	localparam int MseW = 18;
	localparam int DbW = 15;
	localparam int LogFracBits = 26;
	localparam int LogW = 31;
	localparam logic [SqSumW-1:0] SqSumMax = {SqSumW{1'b1}};
	localparam logic [MseW-1:0] MseMax = {MseW{1'b1}};
	localparam logic [29:0] DbScaleQ20 = 30'd808071242;
	localparam logic [DbW-1:0] DbMax = 15'sd16383;
	localparam logic [17:0] PeakSq = 18'd65025;
	localparam int QueueDepth = 2;

	localparam logic [1:0] RegLuma = 2'd0;
	localparam logic [1:0] RegChromaB = 2'd1;
	localparam logic [1:0] RegChromaR = 2'd2;

	typedef struct packed {
		logic [7:0] decoded_pixel;
		logic [7:0] reference_pixel;
	} pix_in_t;

	typedef struct packed {
		logic signed [DbW-1:0] psnr_db_q8;
		logic perfect_match;
		logic [MseW-1:0] mse_total;
	} psnr_out_t;

	// One finished plane, handed from the accumulator to the back end.
	typedef struct packed {
		logic [SqSumW-1:0] sq_sum;
		logic [CountW-1:0] size;
		logic last_plane;
	} plane_job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_ADD,
		BK_LOG,
		BK_MUL,
		BK_OUT
	} bk_state_t;

	function automatic logic [CountW-1:0] clamp_size(input logic [CountW-1:0] s);
		logic [CountW-1:0] r;
		r = s;
		if (s == '0) begin
			r = CountW'(1);
		end else if ({1'b0, s} > (CountW+1)'(MaxPlanePixels)) begin
			r = CountW'(MaxPlanePixels);
		end
		return r;
	endfunction

	// log2 of a nonzero value in Q.26, built the same way as the iterative
	// log unit: leading one position, then one fraction bit per squaring.
	function automatic logic [LogW-1:0] log2_fixed(input logic [MseW-1:0] x);
		logic [63:0] m;
		logic [4:0] n;
		logic [LogFracBits-1:0] frac;
		n = '0;
		frac = '0;
		for (int i = 0; i < MseW; i++) begin
			if (x[i]) n = 5'(i);
		end
		m = 64'(x) << (31 - n);
		for (int i = 0; i < LogFracBits; i++) begin
			m = (m * m) >> 31;
			frac = {frac[LogFracBits-2:0], m[32]};
			if (m[32]) m = m >> 1;
		end
		return {n, frac};
	endfunction

endpackage
`default_nettype wire

// ===== design/three_plane_psnr_meter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: each plane's queued job is divided and added to give its MSE; after the third plane
// the back end also runs log and multiply before output, and a zero total goes straight to output.
// Throughput: one pixel transaction per cycle; the back end is busy with each plane end, so
// shorter planes stall the input via the two-entry job queue.
// Reset: arst_n clears all counters and sums and sets each plane size register to 1.
module three_plane_psnr_meter_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire tpm_pkg::pix_in_t in_data,
	input wire logic in_valid,
	output logic in_ready,
	output tpm_pkg::psnr_out_t out_data,
	output logic out_valid,
	input wire logic out_ready,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import tpm_pkg::*;

	logic [CountW-1:0] luma_q, cb_q, cr_q;
	plane_job_t fr_job, q_job;
	logic fr_push, q_full, q_nonempty, q_pop;
	logic in_fire;
	logic wr_en;

	// The front accepts a pixel transaction whenever a plane end could still be queued.
	assign in_ready = !q_full;
	assign in_fire = in_valid && in_ready;
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_q <= CountW'(1);
			cb_q <= CountW'(1);
			cr_q <= CountW'(1);
		end else if (wr_en) begin
			case (paddr[3:2])
				RegLuma: luma_q <= pwdata[CountW-1:0];
				RegChromaB: cb_q <= pwdata[CountW-1:0];
				RegChromaR: cr_q <= pwdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			RegLuma: prdata = {9'd0, luma_q};
			RegChromaB: prdata = {9'd0, cb_q};
			RegChromaR: prdata = {9'd0, cr_q};
			default: prdata = '0;
		endcase
	end

	tpm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .in_fire(in_fire),
		.size_luma(luma_q), .size_cb(cb_q), .size_cr(cr_q),
		.job(fr_job), .job_push(fr_push)
	);

	tpm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_data(fr_job), .push(fr_push),
		.full(q_full), .pop_data(q_job), .nonempty(q_nonempty), .pop(q_pop)
	);

	tpm_back u_back (
		.clk(clk), .arst_n(arst_n), .job(q_job), .job_valid(q_nonempty),
		.job_pop(q_pop), .res(out_data), .res_valid(out_valid), .res_ready(out_ready)
	);

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n) pready)
	else $error("pready low");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
	else $error("input valid dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
	else $error("output valid dropped");
`endif
endmodule
`default_nettype wire

// ===== design/tpm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpm_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire tpm_pkg::pix_in_t in_data,
	input wire logic in_fire,
	input wire logic [tpm_pkg::CountW-1:0] size_luma,
	input wire logic [tpm_pkg::CountW-1:0] size_cb,
	input wire logic [tpm_pkg::CountW-1:0] size_cr,
	output tpm_pkg::plane_job_t job,
	output logic job_push
);
	import tpm_pkg::*;

	logic [1:0] plane_q;
	logic [CountW-1:0] count_q;
	logic [SqSumW-1:0] sum_q;
	logic [7:0] diff;
	logic [15:0] sq;
	logic [SqSumW:0] sum_next;
	logic [SqSumW-1:0] sum_sat;
	logic [CountW-1:0] size;
	logic [CountW:0] count_next;
	logic plane_end;

	always_comb begin
		diff = (in_data.decoded_pixel > in_data.reference_pixel) ?
			in_data.decoded_pixel - in_data.reference_pixel :
			in_data.reference_pixel - in_data.decoded_pixel;
		sq = diff * diff;
		sum_next = {1'b0, sum_q} + (SqSumW+1)'(sq);
		sum_sat = sum_next[SqSumW] ? SqSumMax : sum_next[SqSumW-1:0];
		case (plane_q)
			2'd0: size = clamp_size(size_luma);
			2'd1: size = clamp_size(size_cb);
			default: size = clamp_size(size_cr);
		endcase
		count_next = {1'b0, count_q} + (CountW+1)'(1);
		plane_end = count_next >= {1'b0, size};
		job.sq_sum = sum_sat;
		job.size = size;
		job.last_plane = ({30'd0, plane_q} == 32'(PlaneCount - 1));
		job_push = in_fire && plane_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
			count_q <= '0;
			sum_q <= '0;
		end else if (in_fire) begin
			if (plane_end) begin
				count_q <= '0;
				sum_q <= '0;
				plane_q <= job.last_plane ? 2'd0 : plane_q + 2'd1;
			end else begin
				count_q <= count_next[CountW-1:0];
				sum_q <= sum_sat;
			end
		end
	end

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		{30'd0, plane_q} < 32'(PlaneCount))
	else $error("plane index out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> count_q == '0 && sum_q == '0)
	else $error("plane accumulator not cleared");
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(count_q) && $stable(plane_q))
	else $error("front state moved without input");
`endif
endmodule
`default_nettype wire

// ===== design/tpm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpm_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire tpm_pkg::plane_job_t push_data,
	input wire logic push,
	output logic full,
	output tpm_pkg::plane_job_t pop_data,
	output logic nonempty,
	input wire logic pop
);
	import tpm_pkg::*;

	plane_job_t slot_q [QueueDepth];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(QueueDepth));
	assign nonempty = (cnt_q != '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full && !pop))
	else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !nonempty))
	else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QueueDepth))
	else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

// ===== design/tpm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpm_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire tpm_pkg::plane_job_t job,
	input wire logic job_valid,
	output logic job_pop,
	output tpm_pkg::psnr_out_t res,
	output logic res_valid,
	input wire logic res_ready
);
	import tpm_pkg::*;

	bk_state_t state_q, state_d;
	// Restoring divider: remainder and quotient share one register pair.
	logic [SqSumW-1:0] quo_q;
	logic [CountW:0] rem_q;
	logic [CountW-1:0] dvs_q;
	logic [5:0] step_q;
	logic last_q;
	logic [MseW-1:0] mse_q;
	logic [MseW-1:0] total_q;
	// Log unit: mantissa squared one fraction bit per cycle.
	logic [32:0] man_q;
	logic [LogFracBits-1:0] frac_q;
	logic [4:0] int_q;
	logic [30:0] mag_q;
	logic neg_q;
	logic [61:0] prod_q;
	logic [1:0] mul_q;
	psnr_out_t res_q;
	logic res_valid_q;

	logic [CountW:0] rem_sh;
	logic [CountW:0] rem_sub;
	logic [MseW:0] mse_add;
	logic [65:0] msq;
	logic [32:0] msq_sh;
	logic [4:0] lead;
	logic [LogW-1:0] logx;
	logic [LogW-1:0] logpeak;
	logic [46:0] rnd;
	logic [14:0] rmag;

	// log2(65025) in Q.26, matches the iterative unit bit for bit.
	localparam logic [LogW-1:0] LogPeakQ26 = log2_fixed(PeakSq);

	always_comb begin
		rem_sh = {rem_q[CountW-1:0], quo_q[SqSumW-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		mse_add = {1'b0, mse_q} + {1'b0, quo_q[MseW-1:0]};
		msq = man_q[31:0] * man_q[31:0];
		msq_sh = msq[63:31];
		lead = '0;
		for (int i = 0; i < MseW; i++) begin
			if (total_q[i]) lead = 5'(i);
		end
		logx = {int_q, frac_q};
		logpeak = LogPeakQ26;
		rnd = 47'((prod_q + (62'd1 << 45)) >> 46);
		rmag = (rnd > 47'd16384) ? 15'd16384 : rnd[14:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (job_valid) state_d = BK_DIV;
			BK_DIV: if (step_q == 6'(SqSumW - 1)) state_d = BK_ADD;
			BK_ADD: begin
				if (!last_q) state_d = BK_IDLE;
				else if (mse_add[MseW] || mse_add[MseW-1:0] != '0) state_d = BK_LOG;
				else state_d = BK_OUT;
			end
			BK_LOG: if (step_q == 6'(LogFracBits)) state_d = BK_MUL;
			BK_MUL: if (mul_q == 2'd1) state_d = BK_OUT;
			BK_OUT: if (!res_valid_q || res_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop = (state_q == BK_IDLE) && job_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			mse_q <= '0;
			res_valid_q <= 1'b0;
			step_q <= '0;
			mul_q <= '0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && res_ready && state_q != BK_OUT) res_valid_q <= 1'b0;
			case (state_q)
				BK_IDLE: begin
					step_q <= '0;
					if (job_valid) begin
						quo_q <= job.sq_sum;
						rem_q <= '0;
						dvs_q <= job.size;
						last_q <= job.last_plane;
					end
				end
				BK_DIV: begin
					step_q <= step_q + 6'd1;
					if (!rem_sub[CountW]) begin
						rem_q <= rem_sub;
						quo_q <= {quo_q[SqSumW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[SqSumW-2:0], 1'b0};
					end
				end
				BK_ADD: begin
					// Quotient above the MSE range saturates the sum.
					if (mse_add[MseW] || quo_q[SqSumW-1:MseW] != '0) begin
						total_q <= MseMax;
					end else begin
						total_q <= mse_add[MseW-1:0];
					end
					if (last_q) mse_q <= '0;
					else mse_q <= (mse_add[MseW] || quo_q[SqSumW-1:MseW] != '0) ?
						MseMax : mse_add[MseW-1:0];
					step_q <= '0;
				end
				BK_LOG: begin
					step_q <= step_q + 6'd1;
					if (step_q == '0) begin
						int_q <= lead;
						man_q <= 33'({14'd0, total_q} << (5'd31 - lead));
						frac_q <= '0;
					end else if (msq_sh[32]) begin
						man_q <= {1'b0, msq_sh[32:1]};
						frac_q <= {frac_q[LogFracBits-2:0], 1'b1};
					end else begin
						man_q <= msq_sh;
						frac_q <= {frac_q[LogFracBits-2:0], 1'b0};
					end
					mul_q <= '0;
				end
				BK_MUL: begin
					mul_q <= mul_q + 2'd1;
					if (mul_q == 2'd0) begin
						neg_q <= logx > logpeak;
						mag_q <= (logx > logpeak) ? logx - logpeak : logpeak - logx;
					end else begin
						prod_q <= mag_q * DbScaleQ20;
					end
				end
				BK_OUT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						res_q.mse_total <= total_q;
						res_q.perfect_match <= (total_q == '0);
						if (total_q == '0) res_q.psnr_db_q8 <= DbMax;
						else if (neg_q) res_q.psnr_db_q8 <= -$signed({1'b0, rmag[13:0]})
							- ((rmag[14]) ? 15'sd16384 : 15'sd0);
						else res_q.psnr_db_q8 <= (rmag > 15'd16383) ? DbMax : rmag;
					end
				end
				default: ;
			endcase
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> state_q == BK_DIV)
	else $error("job popped without divide");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
	else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == BK_OUT)
	else $error("result raised outside output step");
`endif
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import tpm_pkg::*;

	// Clock, reset and the ports of the meter.
	logic clk;
	logic arst_n;
	pix_in_t in_data;
	logic in_valid;
	logic in_ready;
	psnr_out_t out_data;
	logic out_valid;
	logic out_ready;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	three_plane_psnr_meter_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// The clock runs with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Shadow copy of the meter: plane size registers and the frame state.
	logic [CountW-1:0] size_reg [PlaneCount];
	int unsigned frame_plane;
	logic [63:0] plane_pixels;
	logic [63:0] plane_energy;
	logic [63:0] mse_accum;

	// Expected frame results, oldest first.
	psnr_out_t frame_results [$];

	int err_count;
	int pixels_sent;
	int frames_seen;
	int perfect_seen;
	bit calm;
	bit hold_req;

	// One row of the directed stimulus. Where the expected result is obvious
	// it is written into the row; otherwise the shadow model supplies it.
	typedef struct {
		logic [7:0] dec;
		logic [7:0] refp;
		bit known;
		psnr_out_t res;
	} stim_row_t;
	stim_row_t dir_rows [$];

	task automatic add_row(input logic [7:0] dec, input logic [7:0] refp, input bit known,
			input logic signed [DbW-1:0] db, input logic pm, input logic [MseW-1:0] total);
		stim_row_t row;
		row.dec = dec;
		row.refp = refp;
		row.known = known;
		row.res.psnr_db_q8 = db;
		row.res.perfect_match = pm;
		row.res.mse_total = total;
		dir_rows.push_back(row);
	endtask

	// log2 in unsigned Q.26. The integer part is the position of the leading
	// one; each fraction bit comes from squaring the Q1.31 mantissa and
	// checking whether it reached two.
	function automatic logic [63:0] log2_q26(input logic [63:0] x);
		logic [63:0] n;
		logic [63:0] m;
		logic [63:0] frac;
		n = 0;
		frac = 0;
		if (x == 0) begin
			return 64'd0;
		end
		while (n < 63 && (x >> (n + 1)) != 0) begin
			n = n + 1;
		end
		m = x << (31 - n);
		for (int i = 0; i < LogFracBits; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		return (n << LogFracBits) | frac;
	endfunction

	// PSNR in Q8 dB: the log2 difference scaled by 10*log10(2), rounded half
	// away from zero and clamped to the 15-bit signed range.
	function automatic logic signed [DbW-1:0] db_from_total(input logic [63:0] total);
		logic [63:0] la;
		logic [63:0] lb;
		logic [63:0] mag;
		logic [63:0] r;
		bit neg;
		longint v;
		if (total == 0) begin
			return 15'sd16383;
		end
		la = log2_q26(64'd65025);
		lb = log2_q26(total);
		neg = lb > la;
		mag = neg ? lb - la : la - lb;
		r = (mag * 64'd808071242 + (64'd1 << 45)) >> 46;
		if (r > 16384) begin
			r = 16384;
		end
		v = neg ? -longint'(r) : longint'(r);
		if (v > 16383) begin
			v = 16383;
		end
		if (v < -16384) begin
			v = -16384;
		end
		return DbW'(v);
	endfunction

	// Effective plane length: zero counts as one, and the length is capped.
	function automatic logic [63:0] plane_len(input int unsigned p);
		logic [63:0] s;
		s = size_reg[p > 2 ? 2 : p];
		if (s == 0) begin
			s = 1;
		end
		if (s > MaxPlanePixels) begin
			s = MaxPlanePixels;
		end
		return s;
	endfunction

	// Advances the shadow state by one pixel pair. A plane ends at the first
	// pixel with which the count reaches or passes the current length, so a
	// length lowered mid-plane ends it on the next pixel.
	function automatic bit account_pixel(input pix_in_t p, output psnr_out_t res);
		logic [63:0] diff;
		logic [63:0] len;
		logic [63:0] total;
		diff = p.decoded_pixel > p.reference_pixel ?
			64'(p.decoded_pixel - p.reference_pixel) :
			64'(p.reference_pixel - p.decoded_pixel);
		len = plane_len(frame_plane);
		res = '0;
		plane_energy = plane_energy + diff * diff;
		if (plane_energy > 64'(SqSumMax)) begin
			plane_energy = 64'(SqSumMax);
		end
		plane_pixels = plane_pixels + 1;
		if (plane_pixels < len) begin
			return 1'b0;
		end
		mse_accum = mse_accum + plane_energy / len;
		if (mse_accum > 64'(MseMax)) begin
			mse_accum = 64'(MseMax);
		end
		plane_energy = 0;
		plane_pixels = 0;
		frame_plane = frame_plane + 1;
		if (frame_plane < PlaneCount) begin
			return 1'b0;
		end
		total = mse_accum;
		frame_plane = 0;
		mse_accum = 0;
		res.psnr_db_q8 = db_from_total(total);
		res.perfect_match = (total == 0);
		res.mse_total = total[MseW-1:0];
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// Random gap before a transaction: mostly none or short, a few long.
	function automatic int pick_gap();
		if (calm) begin
			return 0;
		end
		if ($urandom_range(0, 9) < 6) begin
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	// Offers one pixel pair and returns at the edge where it is accepted.
	// The expected result, if the pixel closes a frame, is queued then.
	task automatic send_pixel(input pix_in_t p, input bit known, input psnr_out_t known_res);
		int gap;
		psnr_out_t res;
		bit emits;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do begin
			@(posedge clk);
		end while (!in_ready);
		pixels_sent++;
		emits = account_pixel(p, res);
		if (known && !emits) begin
			report_mismatch("directed row produced no frame", 0, 1);
		end
		if (emits) begin
			frame_results.push_back(known ? known_res : res);
		end
	endtask

	// Waits until every expected frame result has arrived and the back end
	// has had time to finish plane ends that produce no result.
	task automatic settle();
		in_valid <= 1'b0;
		while (frame_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (150) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the
	// value at the edge that ends the access cycle.
	task automatic reg_write(input logic [1:0] idx, input logic [CountW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_reg[idx] = value;
	endtask

	// Result side: checks each transaction against the oldest expectation and
	// stalls at random. A requested hold-off keeps ready low for a long,
	// counted stretch so that the job queue fills and the input backs up.
	initial begin : result_side
		int stall_left;
		int hold_left;
		psnr_out_t want;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (frame_results.size() == 0) begin
					report_mismatch("unexpected frame result, mse_total", out_data.mse_total, -1);
				end else begin
					want = frame_results.pop_front();
					frames_seen++;
					if (want.perfect_match) begin
						perfect_seen++;
					end
					if (out_data.psnr_db_q8 !== want.psnr_db_q8) begin
						report_mismatch("psnr_db_q8", out_data.psnr_db_q8, want.psnr_db_q8);
					end
					if (out_data.perfect_match !== want.perfect_match) begin
						report_mismatch("perfect_match", out_data.perfect_match,
							want.perfect_match);
					end
					if (out_data.mse_total !== want.mse_total) begin
						report_mismatch("mse_total", out_data.mse_total, want.mse_total);
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) begin
					stall_left = ($urandom_range(0, 15) == 0) ?
						$urandom_range(20, 80) : $urandom_range(1, 4);
				end
			end
		end
	end

	// Safety net against a hung handshake.
	initial begin : watchdog
		#4000000;
		$display("timeout at %0t", $realtime);
		$display("testbench: errors");
		$finish;
	end

	initial begin : stimulus
		pix_in_t p;
		psnr_out_t none;
		int frames;
		int count;
		int mode;
		int phase;
		logic [CountW-1:0] lens [PlaneCount];

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		err_count = 0;
		pixels_sent = 0;
		frames_seen = 0;
		perfect_seen = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		none = '0;
		for (int i = 0; i < PlaneCount; i++) begin
			size_reg[i] = CountW'(1);
		end
		frame_plane = 0;
		plane_pixels = 0;
		plane_energy = 0;
		mse_accum = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, with every plane one pixel long after reset.
		// Identical frame: perfect match and saturated dB.
		add_row(8'd0, 8'd0, 0, '0, 1'b0, '0);
		add_row(8'd255, 8'd255, 0, '0, 1'b0, '0);
		add_row(8'd128, 8'd128, 1, 15'sd16383, 1'b1, 18'd0);
		// A total equal to the peak power gives exactly 0 dB.
		add_row(8'd255, 8'd0, 0, '0, 1'b0, '0);
		add_row(8'd7, 8'd7, 0, '0, 1'b0, '0);
		add_row(8'd0, 8'd0, 1, 15'sd0, 1'b0, 18'd65025);
		// Largest possible total, the lowest dB.
		add_row(8'd255, 8'd0, 0, '0, 1'b0, '0);
		add_row(8'd0, 8'd255, 0, '0, 1'b0, '0);
		add_row(8'd255, 8'd0, 1, DbW'(db_from_total(64'd195075)), 1'b0, 18'd195075);
		// Smallest nonzero total, the highest finite dB.
		add_row(8'd1, 8'd0, 0, '0, 1'b0, '0);
		add_row(8'd200, 8'd200, 0, '0, 1'b0, '0);
		add_row(8'd9, 8'd9, 0, '0, 1'b0, '0);
		// Alternating bit and nibble patterns, then pairs around midscale and the ends.
		add_row(8'hAA, 8'h55, 0, '0, 1'b0, '0);
		add_row(8'h55, 8'hAA, 0, '0, 1'b0, '0);
		add_row(8'h0F, 8'hF0, 0, '0, 1'b0, '0);
		add_row(8'd128, 8'd127, 0, '0, 1'b0, '0);
		add_row(8'd127, 8'd128, 0, '0, 1'b0, '0);
		add_row(8'd254, 8'd1, 0, '0, 1'b0, '0);
		foreach (dir_rows[i]) begin
			p.decoded_pixel = dir_rows[i].dec;
			p.reference_pixel = dir_rows[i].refp;
			send_pixel(p, dir_rows[i].known, dir_rows[i].res);
		end
		settle();

		// A zero length counts as one, and the register maximum is capped.
		// The second plane is then shortened below the pixels already taken,
		// so it has to end on the very next pixel.
		reg_write(RegLuma, CountW'(0));
		reg_write(RegChromaB, {CountW{1'b1}});
		reg_write(RegChromaR, CountW'(2));
		for (int i = 0; i < 6; i++) begin
			p.decoded_pixel = 8'(i * 40);
			p.reference_pixel = 8'(255 - i * 30);
			send_pixel(p, 0, none);
		end
		settle();
		reg_write(RegChromaB, CountW'(3));
		for (int i = 0; i < 3; i++) begin
			p.decoded_pixel = 8'(i * 90);
			p.reference_pixel = 8'(i * 3);
			send_pixel(p, 0, none);
		end
		settle();

		// Random phases: new plane lengths, then frames of random content.
		// Some phases stop mid-frame, so the next lengths may cut a plane short.
		phase = 0;
		while (pixels_sent < 1550) begin
			calm = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < PlaneCount; i++) begin
				case ($urandom_range(0, 9))
					0: lens[i] = CountW'(0);
					1: lens[i] = CountW'(1);
					2: lens[i] = CountW'($urandom_range(40, 90));
					default: lens[i] = CountW'($urandom_range(1, 12));
				endcase
			end
			if (phase == 3) begin
				// Single-pixel planes with a stalled receiver back up the input.
				lens[0] = CountW'(1);
				lens[1] = CountW'(1);
				lens[2] = CountW'(1);
				hold_req = 1'b1;
			end
			reg_write(RegLuma, lens[0]);
			reg_write(RegChromaB, lens[1]);
			reg_write(RegChromaR, lens[2]);
			frames = (phase == 3) ? 20 : $urandom_range(1, 4);
			count = 0;
			for (int i = 0; i < PlaneCount; i++) begin
				count += (lens[i] == 0) ? 1 : int'(lens[i]);
			end
			count = count * frames;
			if ($urandom_range(0, 3) == 0) begin
				count += $urandom_range(1, 10);
			end
			// Keep the total close to the planned number of transactions.
			if (pixels_sent + count > 1560) begin
				count = 1560 - pixels_sent;
			end
			mode = $urandom_range(0, 5);
			for (int n = 0; n < count; n++) begin
				if (n % 16 == 0 && $urandom_range(0, 3) == 0) begin
					mode = $urandom_range(0, 5);
				end
				p.decoded_pixel = 8'($urandom_range(0, 255));
				case (mode)
					0: p.reference_pixel = p.decoded_pixel;
					1, 2: p.reference_pixel = p.decoded_pixel + 8'($urandom_range(0, 2))
						- 8'($urandom_range(0, 2));
					default: p.reference_pixel = 8'($urandom_range(0, 255));
				endcase
				send_pixel(p, 0, none);
			end
			settle();
			phase++;
		end
		calm = 1'b0;
		settle();

		$display("covered %0d pixel transactions in %0d phases", pixels_sent, phase + 2);
		$display("checked %0d frame results, %0d of them perfect matches",
			frames_seen, perfect_seen);
		if (err_count == 0 && frame_results.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
